// File: rtl/sih_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sih_pkg
// Shared constants for the string-intern hash table.
// ----------------------------------------------------------------------------
package sih_pkg;

    localparam int SLOTS_DEFAULT    = 256;
    localparam int MAX_KEY_DEFAULT  = 16;

    localparam int HASH_W           = 32;
    localparam int TS_W             = 9;
    localparam int ID_W             = 8;
    localparam int CNT_W            = 9;
    localparam int STATUS_W         = 2;

    localparam logic [HASH_W-1:0] HASH_SEED = 32'd63689;
    localparam logic [HASH_W-1:0] HASH_STEP = 32'd378551;
    localparam logic [CNT_W-1:0]  ID_LIMIT  = 9'd256;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LNG = 2'd2;

endpackage

// File: rtl/string_intern_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_intern_hash_table
// String-interning table: RS hash, linear probing, sequential key ids.
// ----------------------------------------------------------------------------
// Key bytes arrive one request at a time; tlast marks the final byte and tuser
// carries the mode (0 query, 1 intern) of the final byte. Each byte is taken,
// then goes twice through the shared 32x32 multiplier (hash update, then
// multiplier update). A final byte of a key that fits then goes through a
// bit-serial remainder unit for hash mod table_size, followed by the probe:
// a slot header read per probed slot plus a read per compared key byte, and
// on insert a header write and a copy of the key into the slot. One result
// request follows each final byte. After reset the block clears the slot
// headers before it takes any key byte; table_size may be written then.
module string_intern_hash_table #(
    parameter int SLOTS         = sih_pkg::SLOTS_DEFAULT,
    parameter int MAX_KEY_BYTES = sih_pkg::MAX_KEY_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [8:0]  i_cfg_wr_data,      // table_size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,       // [7:0] key_byte
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,       // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata        // [0] found, [8:1] key_id, [10:9] status
);

    localparam int SW  = $clog2(SLOTS);
    localparam int LW  = $clog2(MAX_KEY_BYTES + 2);
    localparam int KW  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int PW  = (SW > sih_pkg::TS_W) ? SW + 1 : sih_pkg::TS_W + 1;
    localparam int MW  = 1 + sih_pkg::ID_W + LW;
    localparam int HW  = sih_pkg::HASH_W;
    localparam int TW  = sih_pkg::TS_W;
    localparam int DCW = $clog2(HW);
    localparam logic [PW-1:0] SLOTS_P = PW'(SLOTS);
    localparam logic [TW-1:0] TS_RST  = (SLOTS < 256) ? TW'(SLOTS) : TW'(256);
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_KEY_BYTES);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_MULT  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_PRD   = 4'd5;
    localparam logic [3:0] S_PCHK  = 4'd6;
    localparam logic [3:0] S_CRD   = 4'd7;
    localparam logic [3:0] S_CCHK  = 4'd8;
    localparam logic [3:0] S_INS   = 4'd9;
    localparam logic [3:0] S_COPY  = 4'd10;
    localparam logic [3:0] S_RES   = 4'd11;

    logic [3:0]                r_state, n_state;
    logic [TW-1:0]             r_ts;
    logic [HW-1:0]             r_hash, n_hash;
    logic [HW-1:0]             r_mult, n_mult;
    logic [LW-1:0]             r_klen;
    logic [7:0]                r_kbuf [MAX_KEY_BYTES];
    logic [7:0]                r_byte;
    logic                      r_last, r_mode;
    logic [HW-1:0]             r_q, n_q;
    logic [TW-1:0]             r_rem, n_rem;
    logic [DCW-1:0]            r_dcnt, n_dcnt;
    logic [SW-1:0]             r_cur, n_cur;
    logic [TW-1:0]             r_n, n_n;
    logic [LW-1:0]             r_j, n_j;
    logic [sih_pkg::CNT_W-1:0] r_count, n_count;
    logic [SW-1:0]             r_clr;
    logic                      r_ovalid;
    logic                      r_found, n_found;
    logic [7:0]                r_oid, n_oid;
    logic [1:0]                r_ost, n_ost;

    logic [MW-1:0]             r_meta_mem [SLOTS];
    logic [MW-1:0]             r_meta_q;
    logic [7:0]                r_key_mem [SLOTS << KW];
    logic [7:0]                r_key_q;

    logic [HW-1:0]             mul_b;
    logic [2*HW-1:0]           product;
    logic [TW:0]               div_t;
    logic                      meta_used;
    logic [7:0]                meta_id;
    logic [LW-1:0]             meta_len;
    logic                      meta_we;
    logic [SW-1:0]             meta_addr;
    logic [MW-1:0]             meta_wdata;
    logic                      key_we;
    logic [SW+KW-1:0]          key_addr;
    logic [7:0]                kbuf_j;
    logic                      probe_end;
    logic [SW-1:0]             cur_inc;
    logic                      in_acc, out_free;
    logic [PW-1:0]             cfg_v;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;

    assign mul_b   = (r_state == S_HASH) ? r_hash : sih_pkg::HASH_STEP;
    assign product = r_mult * mul_b;
    assign div_t   = {r_rem, r_q[HW-1]};

    assign meta_used = r_meta_q[MW-1];
    assign meta_id   = r_meta_q[MW-2 -: 8];
    assign meta_len  = r_meta_q[LW-1:0];
    assign kbuf_j    = r_kbuf[r_j[KW-1:0]];
    assign probe_end = (TW'(r_n + 1'b1) == r_ts) || (r_n == {TW{1'b1}});
    assign cur_inc   = (PW'(r_cur) + 1'b1 == PW'(r_ts)) ? '0 : SW'(r_cur + 1'b1);
    assign cfg_v     = PW'(i_cfg_wr_data);

    always_comb begin
        meta_we    = 1'b0;
        meta_addr  = r_cur;
        meta_wdata = {1'b1, r_count[7:0], r_klen};
        key_we     = (r_state == S_COPY);
        key_addr   = {r_cur, r_j[KW-1:0]};
        if (r_state == S_CLR) begin
            meta_we    = 1'b1;
            meta_addr  = r_clr;
            meta_wdata = '0;
        end else if (r_state == S_INS) begin
            meta_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[meta_addr] <= meta_wdata;
        end
        if (r_state == S_PRD) begin
            r_meta_q <= r_meta_mem[meta_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[key_addr] <= kbuf_j;
        end
        r_key_q <= r_key_mem[key_addr];
    end

    always_comb begin
        n_state = r_state;
        n_hash  = r_hash;
        n_mult  = r_mult;
        n_q     = r_q;
        n_rem   = r_rem;
        n_dcnt  = r_dcnt;
        n_cur   = r_cur;
        n_n     = r_n;
        n_j     = r_j;
        n_count = r_count;
        n_found = r_found;
        n_oid   = r_oid;
        n_ost   = r_ost;
        case (r_state)
            S_CLR: begin
                if (r_clr == SW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                n_hash  = product[HW-1:0] + HW'(r_byte);
                n_state = S_MULT;
            end
            S_MULT: begin
                n_mult = product[HW-1:0];
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (r_klen > LEN_MAX) begin
                    n_found = 1'b0;
                    n_oid   = '0;
                    n_ost   = sih_pkg::ST_TOO_LNG;
                    n_state = S_RES;
                end else begin
                    n_q     = r_hash;
                    n_rem   = '0;
                    n_dcnt  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_q = {r_q[HW-2:0], 1'b0};
                if (div_t >= {1'b0, r_ts}) begin
                    n_rem = TW'(div_t - {1'b0, r_ts});
                end else begin
                    n_rem = div_t[TW-1:0];
                end
                n_dcnt = DCW'(r_dcnt + 1'b1);
                if (r_dcnt == DCW'(HW - 1)) begin
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                n_found = 1'b0;
                n_oid   = '0;
                n_ost   = sih_pkg::ST_OK;
                n_j     = '0;
                if (!meta_used) begin
                    if (!r_mode) begin
                        n_state = S_RES;
                    end else if (r_count >= sih_pkg::ID_LIMIT) begin
                        n_ost   = sih_pkg::ST_FULL;
                        n_state = S_RES;
                    end else begin
                        n_state = S_INS;
                    end
                end else if (meta_len == r_klen) begin
                    n_state = S_CRD;
                end else if (probe_end) begin
                    n_ost   = sih_pkg::ST_FULL;
                    n_state = S_RES;
                end else begin
                    n_n     = TW'(r_n + 1'b1);
                    n_cur   = cur_inc;
                    n_state = S_PRD;
                end
            end
            S_CRD: begin
                n_state = S_CCHK;
            end
            S_CCHK: begin
                if (r_key_q == kbuf_j) begin
                    if (r_j == LW'(r_klen - 1'b1)) begin
                        n_found = 1'b1;
                        n_oid   = meta_id;
                        n_state = S_RES;
                    end else begin
                        n_j     = LW'(r_j + 1'b1);
                        n_state = S_CRD;
                    end
                end else if (probe_end) begin
                    n_ost   = sih_pkg::ST_FULL;
                    n_state = S_RES;
                end else begin
                    n_n     = TW'(r_n + 1'b1);
                    n_cur   = cur_inc;
                    n_state = S_PRD;
                end
            end
            S_INS: begin
                n_state = S_COPY;
            end
            S_COPY: begin
                n_j = LW'(r_j + 1'b1);
                if (r_j == LW'(r_klen - 1'b1)) begin
                    n_oid   = r_count[7:0];
                    n_count = sih_pkg::CNT_W'(r_count + 1'b1);
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (out_free) begin
                    n_hash  = '0;
                    n_mult  = sih_pkg::HASH_SEED;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (r_state == S_MULT || r_state == S_PCHK) begin
            n_cur = (r_state == S_MULT) ? r_cur : n_cur;
        end
        if (r_state == S_DIV && r_dcnt == DCW'(HW - 1)) begin
            n_cur = SW'(n_rem);
            n_n   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ts     <= TS_RST;
            r_hash   <= '0;
            r_mult   <= sih_pkg::HASH_SEED;
            r_klen   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hash  <= n_hash;
            r_mult  <= n_mult;
            r_count <= n_count;
            if (r_state == S_CLR) begin
                r_clr <= SW'(r_clr + 1'b1);
            end
            if (i_cfg_wr_en) begin
                if (cfg_v == '0) begin
                    r_ts <= TW'(1);
                end else if (cfg_v > SLOTS_P) begin
                    r_ts <= TW'(SLOTS);
                end else begin
                    r_ts <= i_cfg_wr_data;
                end
            end
            if (in_acc && r_klen <= LEN_MAX) begin
                r_klen <= LW'(r_klen + 1'b1);
            end else if (r_state == S_RES && out_free) begin
                r_klen <= '0;
            end
            if (r_state == S_RES && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q     <= n_q;
        r_rem   <= n_rem;
        r_dcnt  <= n_dcnt;
        r_cur   <= n_cur;
        r_n     <= n_n;
        r_j     <= n_j;
        r_found <= n_found;
        r_oid   <= n_oid;
        r_ost   <= n_ost;
        if (in_acc) begin
            r_byte <= s_axis_tdata;
            r_last <= s_axis_tlast;
            r_mode <= s_axis_tuser;
            if (r_klen < LEN_MAX) begin
                r_kbuf[r_klen[KW-1:0]] <= s_axis_tdata;
            end
        end
    end

    logic       r_tfound;
    logic [7:0] r_tid;
    logic [1:0] r_tst;

    always_ff @(posedge i_clk) begin
        if (r_state == S_RES && out_free) begin
            r_tfound <= r_found;
            r_tid    <= r_oid;
            r_tst    <= r_ost;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_tst, r_tid, r_tfound};

endmodule
